@@ src/ttt_pkg.sv @@
// shared constants, types and codes for the time-triggered task table
package ttt_pkg;

    localparam int TASK_SLOTS  = 8;
    localparam int SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int MAX_ITEMS   = 8;
    localparam int RUN_W       = $clog2(MAX_ITEMS + 1);
    localparam int SLOT_ID_W   = 4;
    localparam int TGT_W       = 3;
    localparam int TGT_CMP_W   = 7;
    localparam int TIME_W      = 16;
    localparam int PEND_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    typedef logic [SLOT_W-1:0] t_slot_idx;

    typedef enum logic [1:0] {
        REQ_ADD      = 2'd0,
        REQ_DEL      = 2'd1,
        REQ_TICK     = 2'd2,
        REQ_DISPATCH = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        RESP_ADD  = 2'd0,
        RESP_DEL  = 2'd1,
        RESP_RUN  = 2'd2,
        RESP_NONE = 2'd3
    } t_resp_kind;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2,
        ERR_RSVD  = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SCAN = 2'd1,
        BK_DONE = 2'd2
    } t_back_state;

    typedef struct packed {
        t_req              op;
        logic [TIME_W-1:0] first_delay;
        logic [TIME_W-1:0] repeat_period;
        logic              is_cooperative;
        logic [TGT_W-1:0]  target_slot;
        logic              target_ok;
    } t_cmd;

    typedef struct packed {
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic              coop;
        logic [PEND_W-1:0] pend;
    } t_slot_data;

    typedef struct packed {
        t_resp_kind           kind;
        logic [SLOT_ID_W-1:0] slot_id;
        logic                 ok;
        t_err                 err;
        logic                 last;
    } t_resp;

endpackage

@@ src/ttt_if.sv @@
// request and response channel interfaces
interface ttt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
    logic        is_cooperative;
    logic [2:0]  target_slot;

    modport source (
        output valid, req_type, first_delay, repeat_period, is_cooperative, target_slot,
        input  ready
    );
    modport sink (
        input  valid, req_type, first_delay, repeat_period, is_cooperative, target_slot,
        output ready
    );
endinterface

interface ttt_resp_if;
    logic       valid;
    logic       ready;
    logic [1:0] resp_kind;
    logic [3:0] slot_id;
    logic       ok;
    logic [1:0] error_code;
    logic       last;

    modport source (
        output valid, resp_kind, slot_id, ok, error_code, last,
        input  ready
    );
    modport sink (
        input  valid, resp_kind, slot_id, ok, error_code, last,
        output ready
    );
endinterface

@@ src/ttt_front.sv @@
// request intake: decodes each request and queues it for the table engine
module ttt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ttt_req_if.sink       i_req,
    output logic          o_cmd_v,
    output ttt_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import ttt_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              w_cmd;
    logic              w_push;
    logic              w_pop;

    assign i_req.ready = (r_cnt < QCNT_W'(QUEUE_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_cmd_pop && (r_cnt != '0);
    assign o_cmd_v     = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        w_cmd.op             = t_req'(i_req.req_type);
        w_cmd.first_delay    = i_req.first_delay;
        w_cmd.repeat_period  = i_req.repeat_period;
        w_cmd.is_cooperative = i_req.is_cooperative;
        w_cmd.target_slot    = i_req.target_slot;
        // out-of-range deletes are flagged here so the engine only checks one bit
        w_cmd.target_ok      = (TGT_CMP_W'(i_req.target_slot) < TGT_CMP_W'(TASK_SLOTS));
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= QPTR_W'(r_wp + 1'b1);
            end
            if (w_pop) begin
                r_rp <= QPTR_W'(r_rp + 1'b1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= QCNT_W'(r_cnt + 1'b1);
                2'b01:   r_cnt <= QCNT_W'(r_cnt - 1'b1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/ttt_back.sv @@
// table engine: slot storage, add/delete, slot-by-slot tick and dispatch scans
module ttt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_v,
    input  ttt_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    ttt_resp_if.source    o_resp
);
    import ttt_pkg::*;

    logic [TASK_SLOTS-1:0] r_valid;
    t_slot_data            r_slot [TASK_SLOTS];
    t_err                  r_err, n_err;
    t_back_state           r_state, n_state;
    t_slot_idx             r_idx, n_idx;
    logic                  r_is_tick, n_is_tick;
    logic [RUN_W-1:0]      r_runs, n_runs;
    logic                  r_held_v, n_held_v;
    t_slot_idx             r_held_slot, n_held_slot;
    logic                  r_out_v;
    t_resp                 r_out;

    logic       w_can_push;
    logic       w_push;
    t_resp      w_item;
    logic       w_wr_en;
    t_slot_idx  w_wr_idx;
    logic       w_wr_valid;
    t_slot_data w_wr_data;
    t_slot_idx  w_rd_idx;
    logic       w_rd_valid;
    t_slot_data w_rd;
    t_slot_data w_step;
    logic       w_step_valid;
    logic       w_run;
    logic       w_run_kept;
    logic       w_stall;
    logic       w_full;
    t_slot_idx  w_free;
    logic       w_del_ok;

    assign w_can_push = !r_out_v || o_resp.ready;

    assign w_rd_idx   = (r_state == BK_SCAN) ? r_idx : t_slot_idx'(i_cmd.target_slot);
    assign w_rd_valid = r_valid[w_rd_idx];
    assign w_rd       = r_slot[w_rd_idx];

    // lowest free slot
    always_comb begin
        w_free = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free = t_slot_idx'(i);
            end
        end
    end
    assign w_full   = &r_valid;
    assign w_del_ok = i_cmd.target_ok && w_rd_valid;

    // one slot of a tick or dispatch scan
    always_comb begin
        w_step       = w_rd;
        w_step_valid = w_rd_valid;
        w_run        = 1'b0;
        if (w_rd_valid) begin
            if (r_is_tick) begin
                if (w_rd.delay != '0) begin
                    w_step.delay = TIME_W'(w_rd.delay - 1'b1);
                end else begin
                    if (w_rd.coop) begin
                        if (w_rd.pend != PEND_MAX) begin
                            w_step.pend = PEND_W'(w_rd.pend + 1'b1);
                        end
                    end else begin
                        w_run       = 1'b1;
                        w_step.pend = '0;
                        if (w_rd.period == '0) begin
                            w_step_valid = 1'b0;
                        end
                    end
                    if (w_rd.period != '0) begin
                        w_step.delay = w_rd.period;
                    end
                end
            end else if (w_rd.coop && (w_rd.pend != '0)) begin
                w_run       = 1'b1;
                w_step.pend = PEND_W'(w_rd.pend - 1'b1);
                if (w_rd.period == '0) begin
                    w_step_valid = 1'b0;
                    w_step.pend  = '0;
                end
            end
        end
    end

    // runs beyond the report limit still update the slot but are not reported
    assign w_run_kept = w_run && (r_runs < RUN_W'(MAX_ITEMS));
    // a kept run flushes the previously held event, which needs the output free
    assign w_stall    = (r_state == BK_SCAN) && w_run_kept && r_held_v && !w_can_push;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_v && (i_cmd.op == REQ_TICK || i_cmd.op == REQ_DISPATCH)) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (!w_stall && (r_idx == t_slot_idx'(TASK_SLOTS - 1))) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (w_can_push) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop   = 1'b0;
        w_push      = 1'b0;
        w_item      = '0;
        w_wr_en     = 1'b0;
        w_wr_idx    = w_rd_idx;
        w_wr_valid  = 1'b0;
        w_wr_data   = '0;
        n_err       = r_err;
        n_idx       = r_idx;
        n_is_tick   = r_is_tick;
        n_runs      = r_runs;
        n_held_v    = r_held_v;
        n_held_slot = r_held_slot;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_v) begin
                    unique case (i_cmd.op)
                        REQ_ADD: begin
                            if (w_can_push) begin
                                o_cmd_pop = 1'b1;
                                w_push    = 1'b1;
                                if (w_full) begin
                                    n_err  = ERR_FULL;
                                    w_item = '{kind: RESP_ADD,
                                               slot_id: SLOT_ID_W'(TASK_SLOTS),
                                               ok: 1'b0, err: ERR_FULL, last: 1'b1};
                                end else begin
                                    w_wr_en    = 1'b1;
                                    w_wr_idx   = w_free;
                                    w_wr_valid = 1'b1;
                                    w_wr_data  = '{delay: i_cmd.first_delay,
                                                   period: i_cmd.repeat_period,
                                                   coop: i_cmd.is_cooperative,
                                                   pend: '0};
                                    w_item     = '{kind: RESP_ADD,
                                                   slot_id: SLOT_ID_W'(w_free),
                                                   ok: 1'b1, err: r_err, last: 1'b1};
                                end
                            end
                        end
                        REQ_DEL: begin
                            if (w_can_push) begin
                                o_cmd_pop = 1'b1;
                                w_push    = 1'b1;
                                w_wr_en   = i_cmd.target_ok;
                                if (!w_del_ok) begin
                                    n_err = ERR_EMPTY;
                                end
                                w_item = '{kind: RESP_DEL,
                                           slot_id: SLOT_ID_W'(i_cmd.target_slot),
                                           ok: w_del_ok,
                                           err: (w_del_ok ? r_err : ERR_EMPTY),
                                           last: 1'b1};
                            end
                        end
                        REQ_TICK, REQ_DISPATCH: begin
                            o_cmd_pop = 1'b1;
                            n_idx     = '0;
                            n_runs    = '0;
                            n_held_v  = 1'b0;
                            n_is_tick = (i_cmd.op == REQ_TICK);
                        end
                        default: ;
                    endcase
                end
            end
            BK_SCAN: begin
                if (!w_stall) begin
                    w_wr_en    = 1'b1;
                    w_wr_valid = w_step_valid;
                    w_wr_data  = w_step;
                    n_idx      = t_slot_idx'(r_idx + 1'b1);
                    if (w_run_kept) begin
                        if (r_held_v) begin
                            w_push = 1'b1;
                            w_item = '{kind: RESP_RUN,
                                       slot_id: SLOT_ID_W'(r_held_slot),
                                       ok: 1'b1, err: r_err, last: 1'b0};
                        end
                        n_held_v    = 1'b1;
                        n_held_slot = r_idx;
                        n_runs      = RUN_W'(r_runs + 1'b1);
                    end
                end
            end
            BK_DONE: begin
                if (w_can_push) begin
                    w_push   = 1'b1;
                    n_held_v = 1'b0;
                    if (r_held_v) begin
                        w_item = '{kind: RESP_RUN, slot_id: SLOT_ID_W'(r_held_slot),
                                   ok: 1'b1, err: r_err, last: 1'b1};
                    end else begin
                        w_item = '{kind: RESP_NONE, slot_id: '0,
                                   ok: 1'b1, err: r_err, last: 1'b1};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_slot[w_wr_idx] <= w_wr_data;
        end
        if (w_push) begin
            r_out <= w_item;
        end
        r_idx       <= n_idx;
        r_is_tick   <= n_is_tick;
        r_held_slot <= n_held_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_err    <= ERR_NONE;
            r_state  <= BK_IDLE;
            r_runs   <= '0;
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_valid[w_wr_idx] <= w_wr_valid;
            end
            r_err    <= n_err;
            r_state  <= n_state;
            r_runs   <= n_runs;
            r_held_v <= n_held_v;
            if (w_push) begin
                r_out_v <= 1'b1;
            end else if (o_resp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_resp.valid      = r_out_v;
    assign o_resp.resp_kind  = r_out.kind;
    assign o_resp.slot_id    = r_out.slot_id;
    assign o_resp.ok         = r_out.ok;
    assign o_resp.error_code = r_out.err;
    assign o_resp.last       = r_out.last;

endmodule

@@ src/time_triggered_task_table.sv @@
// Time-triggered task table with TASK_SLOTS (8) slots. Requests enter a two-deep queue,
// so up to two requests are taken while the engine is busy or a response is waiting.
// The engine has one read port on the slot table: add and delete give one response each
// and wait while the response register is occupied and not taken; tick and dispatch visit
// one slot per cycle, pausing only when a kept run must flush the held event to an occupied
// response register, and give up to eight run events, the final one marked last, or a single
// nothing-run response. error_code carries the sticky error after the request; only reset
// clears it.
module time_triggered_task_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttt_req_if.sink    i_req,
    ttt_resp_if.source o_resp
);
    import ttt_pkg::*;

    logic w_cmd_v;
    t_cmd w_cmd;
    logic w_cmd_pop;

    ttt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_cmd_v   (w_cmd_v),
        .o_cmd     (w_cmd),
        .i_cmd_pop (w_cmd_pop)
    );

    ttt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_v   (w_cmd_v),
        .i_cmd     (w_cmd),
        .o_cmd_pop (w_cmd_pop),
        .o_resp    (o_resp)
    );

endmodule

@@ src/ttt_checker.sv @@
// port-level checks on the response channel, bound to the top level
module ttt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_resp_kind,
    input logic [3:0] i_slot_id,
    input logic       i_ok,
    input logic [1:0] i_error_code,
    input logic       i_last
);
    import ttt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_resp_kind, i_slot_id, i_ok, i_error_code, i_last}))
        else $error("response changed while stalled");

    a_single_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_resp_kind == RESP_ADD || i_resp_kind == RESP_DEL) |-> i_last)
        else $error("add or delete reply not marked last");

    a_none_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_resp_kind == RESP_NONE |-> i_slot_id == '0 && i_ok && i_last)
        else $error("malformed nothing-run response");

    a_full_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_resp_kind == RESP_ADD && !i_ok
            |-> i_slot_id == SLOT_ID_W'(TASK_SLOTS) && i_error_code == ERR_FULL)
        else $error("failed add without full error");

    a_empty_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_resp_kind == RESP_DEL && !i_ok |-> i_error_code == ERR_EMPTY)
        else $error("failed delete without empty-slot error");

endmodule

bind time_triggered_task_table ttt_checker u_ttt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_resp.valid),
    .i_out_ready  (o_resp.ready),
    .i_resp_kind  (o_resp.resp_kind),
    .i_slot_id    (o_resp.slot_id),
    .i_ok         (o_resp.ok),
    .i_error_code (o_resp.error_code),
    .i_last       (o_resp.last)
);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the time-triggered task table, predicted replies against the block
import ttt_pkg::*;

typedef struct {
    t_req              op;
    logic [TIME_W-1:0] dly;
    logic [TIME_W-1:0] per;
    logic              coop;
    logic [TGT_W-1:0]  tgt;
} t_req_item;

class slot_table_scoreboard;
    bit                slot_live   [TASK_SLOTS];
    logic [TIME_W-1:0] slot_delay  [TASK_SLOTS];
    logic [TIME_W-1:0] slot_period [TASK_SLOTS];
    bit                slot_coop   [TASK_SLOTS];
    logic [PEND_W-1:0] slot_pend   [TASK_SLOTS];
    t_err              sticky;
    t_resp             expected_replies [$];
    int                mismatches;

    function new();
        for (int i = 0; i < TASK_SLOTS; i++) begin
            clear_slot(i);
        end
        sticky     = ERR_NONE;
        mismatches = 0;
    endfunction

    function void clear_slot(int i);
        slot_live[i]   = 1'b0;
        slot_delay[i]  = '0;
        slot_period[i] = '0;
        slot_coop[i]   = 1'b0;
        slot_pend[i]   = '0;
    endfunction

    // error_code carries the sticky code as it stands after the request
    function void expect_reply(t_resp_kind kind, logic [SLOT_ID_W-1:0] slot, bit ok, bit last);
        t_resp r;
        r.kind    = kind;
        r.slot_id = slot;
        r.ok      = ok;
        r.err     = sticky;
        r.last    = last;
        expected_replies.push_back(r);
    endfunction

    function int outstanding();
        return expected_replies.size();
    endfunction

    function void note_request(t_req_item it);
        int run_list [$];
        int free_idx;
        int n;
        bit ok;
        free_idx = -1;
        case (it.op)
            REQ_ADD: begin
                for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
                    if (!slot_live[i]) free_idx = i;
                end
                if (free_idx < 0) begin
                    sticky = ERR_FULL;
                    expect_reply(RESP_ADD, SLOT_ID_W'(TASK_SLOTS), 1'b0, 1'b1);
                end else begin
                    slot_live[free_idx]   = 1'b1;
                    slot_delay[free_idx]  = it.dly;
                    slot_period[free_idx] = it.per;
                    slot_coop[free_idx]   = it.coop;
                    slot_pend[free_idx]   = '0;
                    expect_reply(RESP_ADD, SLOT_ID_W'(free_idx), 1'b1, 1'b1);
                end
            end
            REQ_DEL: begin
                ok = 1'b0;
                if (int'(it.tgt) < TASK_SLOTS) begin
                    ok = slot_live[it.tgt];
                    clear_slot(int'(it.tgt));
                end
                if (!ok) sticky = ERR_EMPTY;
                expect_reply(RESP_DEL, SLOT_ID_W'(it.tgt), ok, 1'b1);
            end
            default: begin
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (slot_live[i]) begin
                        if (it.op == REQ_TICK) begin
                            if (slot_delay[i] != 0) begin
                                slot_delay[i] = slot_delay[i] - 1'b1;
                            end else begin
                                if (slot_coop[i]) begin
                                    if (slot_pend[i] != PEND_MAX) slot_pend[i] = slot_pend[i] + 1'b1;
                                end else begin
                                    run_list.push_back(i);
                                    slot_pend[i] = '0;
                                    if (slot_period[i] == 0) clear_slot(i);
                                end
                                if (slot_period[i] != 0) slot_delay[i] = slot_period[i];
                            end
                        end else if (slot_coop[i] && slot_pend[i] != 0) begin
                            run_list.push_back(i);
                            slot_pend[i] = slot_pend[i] - 1'b1;
                            if (slot_period[i] == 0) clear_slot(i);
                        end
                    end
                end
                if (run_list.size() == 0) begin
                    expect_reply(RESP_NONE, '0, 1'b1, 1'b1);
                end else begin
                    n = (run_list.size() < MAX_ITEMS) ? run_list.size() : MAX_ITEMS;
                    for (int k = 0; k < n; k++) begin
                        expect_reply(RESP_RUN, SLOT_ID_W'(run_list[k]), 1'b1, k == n - 1);
                    end
                end
            end
        endcase
    endfunction

    function void check_response(t_resp got);
        t_resp want;
        if (expected_replies.size() == 0) begin
            $error("response with nothing expected: resp_kind %0d slot_id %0d",
                   got.kind, got.slot_id);
            mismatches++;
            return;
        end
        want = expected_replies.pop_front();
        if (got.kind !== want.kind) begin
            $error("resp_kind: expected %0d, got %0d", want.kind, got.kind);
            mismatches++;
        end
        if (got.slot_id !== want.slot_id) begin
            $error("slot_id: expected %0d, got %0d", want.slot_id, got.slot_id);
            mismatches++;
        end
        if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            mismatches++;
        end
        if (got.err !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, got.err);
            mismatches++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatches++;
        end
    endfunction
endclass

module tb;

    localparam int SCAN_CYCLES      = TASK_SLOTS + 2;
    localparam int SETTLE_CYCLES    = 3 * SCAN_CYCLES;
    localparam int RESP_HOLD_CYCLES = 150;
    localparam int RANDOM_ITEMS     = 30;
    localparam int SATURATE_TICKS   = 260;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ttt_req_if  u_req ();
    ttt_resp_if u_resp ();

    time_triggered_task_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .o_resp  (u_resp)
    );

    slot_table_scoreboard table_model = new();

    int hold_req_cnt  = 0;
    int hold_done_cnt = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10ms;
        $display("time_triggered_task_table regression: fail");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // small times keep tasks firing; full-width ones exercise every bit
    function automatic logic [TIME_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return TIME_W'($urandom_range(0, 3));
        if (r < 90) return TIME_W'($urandom_range(0, 15));
        return TIME_W'($urandom);
    endfunction

    function automatic t_req_item noise_item();
        t_req_item it;
        it.op   = t_req'($urandom_range(0, 3));
        it.dly  = TIME_W'($urandom);
        it.per  = TIME_W'($urandom);
        it.coop = $urandom_range(0, 1);
        it.tgt  = TGT_W'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic t_req_item mk_add(logic [TIME_W-1:0] dly, logic [TIME_W-1:0] per,
                                         logic coop);
        t_req_item it;
        it      = noise_item();
        it.op   = REQ_ADD;
        it.dly  = dly;
        it.per  = per;
        it.coop = coop;
        return it;
    endfunction

    function automatic t_req_item mk_del(int slot);
        t_req_item it;
        it     = noise_item();
        it.op  = REQ_DEL;
        it.tgt = TGT_W'(slot);
        return it;
    endfunction

    function automatic t_req_item mk_scan(t_req op);
        t_req_item it;
        it    = noise_item();
        it.op = op;
        return it;
    endfunction

    function automatic int pick_live_slot();
        int live [$];
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (table_model.slot_live[i]) live.push_back(i);
        end
        if (live.size() == 0) return $urandom_range(0, TASK_SLOTS - 1);
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // sample both channels at the edge; request first so its replies are queued
    always @(posedge i_clk) begin
        t_req_item seen;
        t_resp     got;
        if (i_rst_n) begin
            if (u_req.valid && u_req.ready) begin
                seen.op   = t_req'(u_req.req_type);
                seen.dly  = u_req.first_delay;
                seen.per  = u_req.repeat_period;
                seen.coop = u_req.is_cooperative;
                seen.tgt  = u_req.target_slot;
                table_model.note_request(seen);
            end
            if (u_resp.valid && u_resp.ready) begin
                got.kind    = t_resp_kind'(u_resp.resp_kind);
                got.slot_id = u_resp.slot_id;
                got.ok      = u_resp.ok;
                got.err     = t_err'(u_resp.error_code);
                got.last    = u_resp.last;
                table_model.check_response(got);
            end
        end
    end

    // response side: random ready gaps, plus a long hold when asked
    initial begin
        int gap;
        int burst;
        u_resp.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req_cnt != hold_done_cnt) begin
                u_resp.ready <= 1'b0;
                repeat (RESP_HOLD_CYCLES) @(posedge i_clk);
                hold_done_cnt++;
            end
            gap = pick_gap();
            if (gap > 0) begin
                u_resp.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            u_resp.ready <= 1'b1;
            burst = $urandom_range(1, 20);
            repeat (burst) @(posedge i_clk);
        end
    end

    int sent_random = 0;

    // called at a clock edge; returns at the edge of the transfer or after the idle gap
    task automatic offer(t_req_item it);
        int gap;
        u_req.valid          <= 1'b1;
        u_req.req_type       <= it.op;
        u_req.first_delay    <= it.dly;
        u_req.repeat_period  <= it.per;
        u_req.is_cooperative <= it.coop;
        u_req.target_slot    <= it.tgt;
        do @(posedge i_clk); while (u_req.ready !== 1'b1);
        gap = pick_gap();
        if (gap > 0) begin
            u_req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        u_req.valid <= 1'b0;
        while (table_model.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_episode();
        int kind;
        int n;
        t_req_item it;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            // well-formed: a few adds, a run of ticks and dispatches, maybe a delete
            n = $urandom_range(1, 3);
            repeat (n) begin
                offer(mk_add(pick_time(), ($urandom_range(0, 3) == 0) ? '0 : pick_time(),
                             $urandom_range(0, 1)));
                sent_random++;
            end
            n = $urandom_range(1, 12);
            repeat (n) begin
                offer(mk_scan(($urandom_range(0, 9) < 7) ? REQ_TICK : REQ_DISPATCH));
                sent_random++;
            end
            if ($urandom_range(0, 1)) begin
                offer(mk_del(pick_live_slot()));
                sent_random++;
            end
        end else if (kind < 8) begin
            n = $urandom_range(2, 6);
            repeat (n) begin
                offer(noise_item());
                sent_random++;
            end
        end else begin
            // broken: deletes of any slot mixed with dispatch bursts
            n = $urandom_range(2, 5);
            repeat (n) begin
                if ($urandom_range(0, 1)) it = mk_del($urandom_range(0, 7));
                else it = mk_scan(REQ_DISPATCH);
                offer(it);
                sent_random++;
            end
        end
    endtask

    initial begin
        bit hold_sent;
        hold_sent             = 1'b0;
        i_rst_n              <= 1'b0;
        u_req.valid          <= 1'b0;
        u_req.req_type       <= REQ_ADD;
        u_req.first_delay    <= '0;
        u_req.repeat_period  <= '0;
        u_req.is_cooperative <= 1'b0;
        u_req.target_slot    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: nothing run, delete of empty slot
        offer(mk_scan(REQ_DISPATCH));
        offer(mk_scan(REQ_TICK));
        offer(mk_del(3));
        // fill with pre-emptive tasks, seven of them zero-delay, then overflow
        offer(mk_add('0, '0, 1'b0));
        offer(mk_add('0, 16'd2, 1'b0));
        offer(mk_add('0, 16'hFFFF, 1'b0));
        offer(mk_add('0, 16'd1, 1'b0));
        offer(mk_add('0, '0, 1'b0));
        offer(mk_add('0, 16'd3, 1'b0));
        offer(mk_add('0, 16'd1, 1'b0));
        offer(mk_add(16'hFFFF, 16'd1, 1'b0));
        offer(mk_add(16'd5, 16'd5, 1'b1));
        drain();
        // eight runs would need slot 7 due now; free it and refill with a due task
        offer(mk_del(7));
        offer(mk_add('0, '0, 1'b0));
        offer(mk_scan(REQ_TICK));
        // one-shot slots retired; cooperative tasks take their place
        offer(mk_add('0, '0, 1'b1));
        offer(mk_add(16'hFFFF, 16'hFFFF, 1'b1));
        offer(mk_scan(REQ_TICK));
        offer(mk_scan(REQ_DISPATCH));
        offer(mk_scan(REQ_DISPATCH));
        offer(mk_del(4));
        offer(mk_del(4));
        drain();

        // pending count saturates on a cooperative task that stays due
        for (int i = 0; i < TASK_SLOTS; i++) begin
            offer(mk_del(i));
        end
        offer(mk_add('0, '0, 1'b1));
        offer(mk_add('0, 16'd1, 1'b1));
        repeat (SATURATE_TICKS) offer(mk_scan(REQ_TICK));
        offer(mk_scan(REQ_DISPATCH));
        offer(mk_scan(REQ_DISPATCH));
        drain();

        while (sent_random < RANDOM_ITEMS) begin
            if (!hold_sent && sent_random >= RANDOM_ITEMS / 3) begin
                hold_req_cnt++;
                hold_sent = 1'b1;
            end
            random_episode();
            if ($urandom_range(0, 99) < 15) drain();
        end

        drain();
        if (table_model.outstanding() != 0) begin
            $error("%0d responses never arrived", table_model.outstanding());
            table_model.mismatches++;
        end
        if (table_model.mismatches == 0) $display("time_triggered_task_table regression: pass");
        else $display("time_triggered_task_table regression: fail");
        $finish;
    end

endmodule

@@ time_triggered_task_table.f @@
src/ttt_pkg.sv
src/ttt_if.sv
src/ttt_front.sv
src/ttt_back.sv
src/time_triggered_task_table.sv
src/ttt_checker.sv
test/tb.sv
